@@ hw/rtl/mlsd_pkg.sv @@
// Shared constants, codes and beat types of the LED scan driver.
package mlsd_pkg;

  localparam int unsigned NumLeds   = 3;
  localparam int unsigned FullLevel = 5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned BlinkW   = 16;
  localparam int unsigned LevelW   = 3;

  localparam logic [BlinkW-1:0] BlinkIvlRst = 16'd333;
  localparam logic [LevelW-1:0] LevelRst    = 3'd5;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpShl   = 2'd2,
    OpShr   = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegScanEn    = 3'd0,
    RegBlinkIvl  = 3'd1,
    RegBlinkMask = 3'd2,
    RegLevel0    = 3'd3,
    RegLevel1    = 3'd4,
    RegLevel2    = 3'd5
  } cfg_reg_e;

  typedef logic [1:0] led_idx_t;

  typedef struct packed {
    logic [1:0] opcode;
    led_idx_t   position;
    logic       value_bit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] pin_code;
    led_idx_t   scan_index;
    logic [2:0] pattern;
  } res_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

@@ hw/rtl/mlsd_if.sv @@
// Valid/ready channel interfaces for command and result beats.
interface mlsd_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] position;
  logic       value_bit;

  modport source (output valid, output opcode, output position, output value_bit,
                  input ready);
  modport sink   (input valid, input opcode, input position, input value_bit,
                  output ready);
endinterface

interface mlsd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] pin_code;
  logic [1:0] scan_index;
  logic [2:0] pattern;

  modport source (output valid, output pin_code, output scan_index, output pattern,
                  input ready);
  modport sink   (input valid, input pin_code, input scan_index, input pattern,
                  output ready);
endinterface

@@ hw/rtl/mlsd_core.sv @@
// Scan state, blink and dim counters, pattern bits and config registers.
module mlsd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mlsd_pkg::cfg_wr_t cfg_i,
  input  logic             fire_i,
  input  mlsd_pkg::cmd_t   cmd_i,
  output mlsd_pkg::res_t   res_o
);
  import mlsd_pkg::*;

  logic                scan_en_q, scan_en_d;
  logic [BlinkW-1:0]   ivl_q, ivl_d;
  logic [NumLeds-1:0]  mask_q, mask_d;
  logic [LevelW-1:0]   level_q [NumLeds];
  logic [LevelW-1:0]   level_d [NumLeds];

  led_idx_t            pos_q, pos_d;
  logic [NumLeds-1:0]  bits_q, bits_d;
  logic [BlinkW-1:0]   cnt_q [NumLeds];
  logic [BlinkW-1:0]   cnt_d [NumLeds];
  logic [NumLeds-1:0]  phase_q, phase_d;
  logic [LevelW-1:0]   dim_q [NumLeds];
  logic [LevelW-1:0]   dim_d [NumLeds];
  logic [1:0]          pins_q, pins_d;

  led_idx_t            nxt_pos;
  logic                tick;
  logic                blink_show;
  logic                shown;

  always_comb begin
    scan_en_d = scan_en_q;
    ivl_d     = ivl_q;
    mask_d    = mask_q;
    level_d   = level_q;
    pos_d     = pos_q;
    bits_d    = bits_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    dim_d     = dim_q;
    pins_d    = pins_q;

    tick       = fire_i && (cmd_i.opcode == OpTick) && scan_en_q;
    nxt_pos    = (pos_q == led_idx_t'(NumLeds - 1)) ? '0 : pos_q + 2'd1;
    blink_show = 1'b1;
    shown      = 1'b1;

    if (tick) begin
      pos_d = nxt_pos;
      // blink: count visits, toggle phase when the interval is reached
      if (mask_q[nxt_pos]) begin
        if (cnt_q[nxt_pos] < ivl_q) begin
          cnt_d[nxt_pos] = cnt_q[nxt_pos] + 16'd1;
        end else begin
          cnt_d[nxt_pos]   = '0;
          phase_d[nxt_pos] = ~phase_q[nxt_pos];
        end
        blink_show = ~phase_d[nxt_pos];
      end
      shown = blink_show;
      // dim: hide one visit in level+1, skip when blinking already hides
      if (blink_show && (32'(level_q[nxt_pos]) < FullLevel)) begin
        if (dim_q[nxt_pos] == level_q[nxt_pos]) begin
          dim_d[nxt_pos] = '0;
          shown          = 1'b0;
        end else begin
          dim_d[nxt_pos] = dim_q[nxt_pos] + 3'd1;
        end
      end
      pins_d = (shown && bits_q[nxt_pos]) ? nxt_pos + 2'd1 : 2'd0;
    end

    if (fire_i) begin
      case (cmd_i.opcode)
        OpWrite: begin
          if (32'(cmd_i.position) < NumLeds) begin
            bits_d[cmd_i.position] = cmd_i.value_bit;
          end
        end
        OpShl: begin
          for (int i = 0; i < NumLeds - 1; i++) begin
            bits_d[i] = bits_q[i+1];
          end
          bits_d[NumLeds-1] = cmd_i.value_bit;
        end
        OpShr: begin
          for (int i = NumLeds - 1; i > 0; i--) begin
            bits_d[i] = bits_q[i-1];
          end
          bits_d[0] = cmd_i.value_bit;
        end
        default: ;
      endcase
    end

    // config writes must arrive only while idle; the core itself does not enforce this
    if (cfg_i.we) begin
      case (cfg_i.idx)
        RegScanEn: scan_en_d = cfg_i.data[0];
        RegBlinkIvl: begin
          ivl_d = cfg_i.data[BlinkW-1:0];
          for (int i = 0; i < NumLeds; i++) cnt_d[i] = '0;
        end
        RegBlinkMask: begin
          mask_d  = cfg_i.data[NumLeds-1:0];
          phase_d = '0;
          for (int i = 0; i < NumLeds; i++) cnt_d[i] = '0;
        end
        RegLevel0: begin
          level_d[0] = cfg_i.data[LevelW-1:0];
          dim_d[0]   = '0;
        end
        RegLevel1: begin
          level_d[1] = cfg_i.data[LevelW-1:0];
          dim_d[1]   = '0;
        end
        RegLevel2: begin
          level_d[2] = cfg_i.data[LevelW-1:0];
          dim_d[2]   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_en_q <= 1'b1;
      ivl_q     <= BlinkIvlRst;
      mask_q    <= '0;
      pos_q     <= '0;
      bits_q    <= '0;
      phase_q   <= '0;
      pins_q    <= '0;
      for (int i = 0; i < NumLeds; i++) begin
        level_q[i] <= LevelRst;
        cnt_q[i]   <= '0;
        dim_q[i]   <= '0;
      end
    end else begin
      scan_en_q <= scan_en_d;
      ivl_q     <= ivl_d;
      mask_q    <= mask_d;
      level_q   <= level_d;
      pos_q     <= pos_d;
      bits_q    <= bits_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      dim_q     <= dim_d;
      pins_q    <= pins_d;
    end
  end

  always_comb begin
    res_o.pin_code              = pins_d;
    res_o.scan_index            = pos_d;
    res_o.pattern               = '0;
    res_o.pattern[NumLeds-1:0]  = bits_d;
  end

endmodule

@@ hw/rtl/multiplexed_led_scan_driver.sv @@
// Top level of the multiplexed LED scan driver with blink and dimming.
//
//   channel   dir   beat fields                        handshake
//   cmd_i     in    opcode, position, value_bit        valid/ready
//   res_o     out   pin_code, scan_index, pattern      valid/ready
//   cfg_*_i   in    cfg_we_i, cfg_idx_i, cfg_data_i     write enable, no wait
//
// One beat per clock sustained while res_o is ready; a command passes from accept
// to result through the input register, then the core update into the result register.
// The input stage refills in the same cycle the result register drains, so
// a stalled result holds the pipe without dropping a beat.
// Reset (rst_ni low, asynchronous) empties both stages and restores the
// register defaults: scan on, blink interval 333, no blinking, full levels.
module multiplexed_led_scan_driver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mlsd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mlsd_pkg::CfgDataW-1:0]      cfg_data_i,
  mlsd_cmd_if.sink                           cmd_i,
  mlsd_res_if.source                         res_o
);
  import mlsd_pkg::*;

  logic    s1_valid_q;
  cmd_t    s1_cmd_q;
  logic    out_valid_q;
  res_t    out_res_q;
  res_t    core_res;
  cfg_wr_t cfg_wr;
  logic    out_free;
  logic    s1_fire;

  // Advance the input stage whenever the result register is empty or draining.
  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign cmd_i.ready = !s1_valid_q || out_free;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      s1_valid_q <= cmd_i.valid;
    end
  end

  // Capture the command beat; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      s1_cmd_q.opcode    <= cmd_i.opcode;
      s1_cmd_q.position  <= cmd_i.position;
      s1_cmd_q.value_bit <= cmd_i.value_bit;
    end
  end

  // The core's scan and pattern state changes only on the cycle the staged command moves on.
  mlsd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_wr),
    .fire_i (s1_fire),
    .cmd_i  (s1_cmd_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_res_q <= core_res;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.pin_code   = out_res_q.pin_code;
  assign res_o.scan_index = out_res_q.scan_index;
  assign res_o.pattern    = out_res_q.pattern;

  // Lit pins always name the scanned LED.
  a_pin_matches_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.pin_code != 2'd0) |->
      (res_o.pin_code == res_o.scan_index + 2'd1))
    else $error("pin code does not match scan index");

  // Full pipe with a stalled result must back-pressure the command side.
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !res_o.ready) |-> !cmd_i.ready)
    else $error("command accepted while pipe is full and stalled");

  // A staged command becomes a result beat on the next cycle it moves.
  a_fire_fills_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("staged command lost");

endmodule

@@ tb/tb_multiplexed_led_scan_driver.sv @@
// Self-checking testbench for the multiplexed LED scan driver.
`timescale 1ns / 100ps

module tb_multiplexed_led_scan_driver;
  import mlsd_pkg::*;

  // Register indexes past the last real register; writes there must do nothing.
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

  // Cycles without any beat before the run is declared hung. The longest
  // legal quiet stretch comes from the result hold-off below.
  localparam int QuietLimit = 2000;
  localparam int HoldOffCycles = 300;
  localparam int IdlePct = 19;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  mlsd_cmd_if cmd_ch ();
  mlsd_res_if res_ch ();

  multiplexed_led_scan_driver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_ch),
    .res_o      (res_ch)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the driver: register copies and scan state.
  // ---------------------------------------------------------------------------
  logic              scan_on;
  logic [BlinkW-1:0] blink_ivl;
  logic [2:0]        blink_sel;
  logic [LevelW-1:0] level_r     [NumLeds];
  led_idx_t          cur_pos;
  logic              led_on      [NumLeds];
  logic [BlinkW-1:0] blink_cnt   [NumLeds];
  logic              blink_dark  [NumLeds];
  logic [2:0]        dim_cnt     [NumLeds];
  logic [1:0]        pins_lit;

  // Frames the driver still owes, oldest first.
  res_t led_frames_due [$];

  int  mismatches    = 0;
  bit  steady        = 1'b0;  // suppress random idling on both sides
  int  hold_off_reqs = 0;     // hold-offs asked for by the tests
  int  hold_off_done = 0;     // hold-offs taken up by the result side
  int  stall_left    = 0;
  int  quiet_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Restore the register defaults and clear the scan state, as reset does.
  task automatic mirror_reset();
    scan_on   = 1'b1;
    blink_ivl = BlinkIvlRst;
    blink_sel = '0;
    cur_pos   = '0;
    pins_lit  = '0;
    for (int i = 0; i < NumLeds; i++) begin
      level_r[i]    = LevelRst;
      led_on[i]     = 1'b0;
      blink_cnt[i]  = '0;
      blink_dark[i] = 1'b0;
      dim_cnt[i]    = '0;
    end
  endtask

  // Apply one register write to the mirror, counters cleared where the
  // register owns them.
  task automatic mirror_reg_write(input logic [CfgIdxW-1:0] idx,
                                  input logic [CfgDataW-1:0] data);
    case (idx)
      RegScanEn: scan_on = data[0];
      RegBlinkIvl: begin
        blink_ivl = data[BlinkW-1:0];
        for (int i = 0; i < NumLeds; i++) blink_cnt[i] = '0;
      end
      RegBlinkMask: begin
        blink_sel = data[2:0];
        for (int i = 0; i < NumLeds; i++) begin
          blink_cnt[i]  = '0;
          blink_dark[i] = 1'b0;
        end
      end
      RegLevel0: begin
        level_r[0] = data[LevelW-1:0];
        dim_cnt[0] = '0;
      end
      RegLevel1: begin
        level_r[1] = data[LevelW-1:0];
        dim_cnt[1] = '0;
      end
      RegLevel2: begin
        level_r[2] = data[LevelW-1:0];
        dim_cnt[2] = '0;
      end
      default: ;
    endcase
  endtask

  // Advance the mirror by one command and return the frame it must produce.
  function automatic res_t led_frame_after(input opcode_e op, input led_idx_t pos,
                                           input logic val_bit);
    res_t frame;
    logic shown;
    case (op)
      OpTick: begin
        if (scan_on) begin
          cur_pos = (cur_pos == led_idx_t'(NumLeds - 1)) ? '0 : cur_pos + 2'd1;
          shown = 1'b1;
          // Blink: count visits up to the interval, then flip the phase.
          if (blink_sel[cur_pos]) begin
            if (blink_cnt[cur_pos] < blink_ivl) begin
              blink_cnt[cur_pos] = blink_cnt[cur_pos] + 16'd1;
            end else begin
              blink_cnt[cur_pos]  = '0;
              blink_dark[cur_pos] = ~blink_dark[cur_pos];
            end
            shown = ~blink_dark[cur_pos];
          end
          // Dim: skip the LED once every level+1 visits; blink-dark visits
          // leave the dim counter alone.
          if (shown && 32'(level_r[cur_pos]) < FullLevel) begin
            if (dim_cnt[cur_pos] == level_r[cur_pos]) begin
              dim_cnt[cur_pos] = '0;
              shown = 1'b0;
            end else begin
              dim_cnt[cur_pos] = dim_cnt[cur_pos] + 3'd1;
            end
          end
          pins_lit = (shown && led_on[cur_pos]) ? cur_pos + 2'd1 : 2'd0;
        end
      end
      OpWrite: begin
        if (32'(pos) < NumLeds) led_on[pos] = val_bit;
      end
      OpShl: begin
        for (int i = 0; i < NumLeds - 1; i++) led_on[i] = led_on[i + 1];
        led_on[NumLeds - 1] = val_bit;
      end
      default: begin
        for (int i = NumLeds - 1; i > 0; i--) led_on[i] = led_on[i - 1];
        led_on[0] = val_bit;
      end
    endcase
    frame.pin_code   = pins_lit;
    frame.scan_index = cur_pos;
    frame.pattern    = '0;
    for (int i = 0; i < NumLeds; i++) frame.pattern[i] = led_on[i];
    return frame;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side: offer one beat, hold it until accepted, log its frame.
  // ---------------------------------------------------------------------------
  task automatic issue_cmd(input opcode_e op, input led_idx_t pos, input logic val_bit);
    while (!steady && $urandom_range(99) < IdlePct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.opcode    <= op;
    cmd_ch.position  <= pos;
    cmd_ch.value_bit <= val_bit;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    led_frames_due.push_back(led_frame_after(op, pos, val_bit));
  endtask

  // Mix: ticks dominate so the scan moves; writes and shifts keep the
  // pattern churning. Position 3 shows up on writes and gets ignored.
  task automatic issue_random_cmd();
    int pick;
    opcode_e op;
    pick = $urandom_range(99);
    if (pick < 55)      op = OpTick;
    else if (pick < 75) op = OpWrite;
    else if (pick < 87) op = OpShl;
    else                op = OpShr;
    issue_cmd(op, led_idx_t'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // Drop valid and wait until every owed frame has come back, then let the
  // two pipeline stages go quiet before touching registers.
  task automatic settle_pipeline();
    cmd_ch.valid <= 1'b0;
    while (led_frames_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Register write; caller guarantees the pipe is empty.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    mirror_reg_write(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Fill the bits above a register's width with noise; they must be dropped.
  function automatic logic [CfgDataW-1:0] with_noise(input logic [CfgDataW-1:0] value,
                                                     input logic [CfgDataW-1:0] keep);
    return (CfgDataW'($urandom) & ~keep) | (value & keep);
  endfunction

  task automatic configure_scan(input logic on, input logic [BlinkW-1:0] ivl,
                                input logic [2:0] sel, input logic [2:0] l0,
                                input logic [2:0] l1, input logic [2:0] l2);
    settle_pipeline();
    write_reg(RegScanEn,    with_noise(16'(on),  16'h0001));
    write_reg(RegBlinkIvl,  ivl);
    write_reg(RegBlinkMask, with_noise(16'(sel), 16'h0007));
    write_reg(RegLevel0,    with_noise(16'(l0),  16'h0007));
    write_reg(RegLevel1,    with_noise(16'(l1),  16'h0007));
    write_reg(RegLevel2,    with_noise(16'(l2),  16'h0007));
  endtask

  task automatic configure_random();
    logic [BlinkW-1:0] ivl;
    ivl = ($urandom_range(9) == 0) ? BlinkW'($urandom) : BlinkW'($urandom_range(6));
    configure_scan($urandom_range(99) < 90, ivl, 3'($urandom_range(7)),
                   3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check every accepted beat, drive ready with random stalls
  // and honor a requested hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : frame_check
    res_t got;
    res_t want;
    if (res_ch.valid && res_ch.ready) begin
      got = {res_ch.pin_code, res_ch.scan_index, res_ch.pattern};
      if (led_frames_due.size() == 0) begin
        $error("result beat with nothing outstanding: %p", got);
        mismatches++;
      end else begin
        want = led_frames_due.pop_front();
        if (got.pin_code !== want.pin_code) begin
          $error("pin_code: expected %0d, got %0d", want.pin_code, got.pin_code);
          mismatches++;
        end
        if (got.scan_index !== want.scan_index) begin
          $error("scan_index: expected %0d, got %0d", want.scan_index, got.scan_index);
          mismatches++;
        end
        if (got.pattern !== want.pattern) begin
          $error("pattern: expected %b, got %b", want.pattern, got.pattern);
          mismatches++;
        end
      end
    end
    if (hold_off_reqs != hold_off_done) begin
      stall_left    = HoldOffCycles;
      hold_off_done = hold_off_reqs;
    end
    if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  // Hang detector: any beat on either channel counts as progress.
  always @(posedge clk_i) begin : hang_watch
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bit writes at every position (position 3 ignored), both shifts with both
  // inserted values, and pins holding their value across non-tick beats.
  task automatic test_pattern_ops();
    issue_cmd(OpWrite, 2'd0, 1'b1);
    issue_cmd(OpWrite, 2'd1, 1'b1);
    issue_cmd(OpWrite, 2'd2, 1'b1);
    issue_cmd(OpWrite, 2'd3, 1'b0);
    issue_cmd(OpTick,  2'd0, 1'b0);
    issue_cmd(OpWrite, 2'd3, 1'b1);
    issue_cmd(OpShl,   2'd3, 1'b0);
    issue_cmd(OpTick,  2'd3, 1'b1);
    issue_cmd(OpShr,   2'd0, 1'b1);
    issue_cmd(OpWrite, 2'd1, 1'b0);
    issue_cmd(OpTick,  2'd1, 1'b0);
    issue_cmd(OpShl,   2'd2, 1'b1);
    issue_cmd(OpShr,   2'd1, 1'b0);
  endtask

  // Ticks freeze with the scan off; writes still land.
  task automatic test_scan_disable();
    settle_pipeline();
    write_reg(RegScanEn, 16'hFFFE);
    issue_cmd(OpTick,  2'd0, 1'b1);
    issue_cmd(OpWrite, 2'd2, 1'b0);
    issue_cmd(OpTick,  2'd2, 1'b0);
    settle_pipeline();
    write_reg(RegScanEn, 16'h0001);
  endtask

  // Level zero hides every visit, six and seven act as always on; writes to
  // the spare indexes change nothing.
  task automatic test_levels_and_spares();
    settle_pipeline();
    write_reg(RegLevel0, 16'h0000);
    write_reg(RegLevel1, 16'hFFF7);
    write_reg(RegLevel2, 16'h0006);
    write_reg(RegSpare6, 16'hFFFF);
    write_reg(RegSpare7, 16'h0000);
    issue_cmd(OpShr,  2'd0, 1'b1);
    repeat (3) issue_cmd(OpTick, 2'd0, 1'b0);
  endtask

  // Blink interval zero: every visit flips the phase.
  task automatic test_fast_blink();
    settle_pipeline();
    write_reg(RegBlinkIvl,  16'h0000);
    write_reg(RegBlinkMask, 16'hFFFF);
    repeat (4) issue_cmd(OpTick, 2'd0, 1'b0);
  endtask

  // Bulk random traffic over a run of settings, extremes first.
  task automatic test_random_scan();
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: configure_scan(1'b1, 16'h0000, 3'd7, 3'd0, 3'd7, 3'd6);
        1: configure_scan(1'b1, 16'hFFFF, 3'd7, 3'd4, 3'd3, 3'd2);
        2: configure_scan(1'b0, 16'd2,    3'd5, 3'd1, 3'd5, 3'd0);
        3: configure_scan(1'b1, 16'd1,    3'd0, 3'd5, 3'd0, 3'd7);
        default: configure_random();
      endcase
      repeat (130) issue_random_cmd();
    end
  endtask

  // Long stretch with no idling on either side.
  task automatic test_steady_stream();
    configure_random();
    steady = 1'b1;
    repeat (200) issue_random_cmd();
    steady = 1'b0;
  endtask

  // Hold the result side off while commands keep coming, so the pipe fills
  // and the command side backs up.
  task automatic test_result_hold_off();
    configure_random();
    hold_off_reqs++;
    repeat (40) issue_random_cmd();
  endtask

  // Pause the command side until every frame is back, then resume.
  task automatic test_sender_pause();
    repeat (15) issue_random_cmd();
    cmd_ch.valid <= 1'b0;
    while (led_frames_due.size() != 0) @(posedge clk_i);
    repeat (15) issue_random_cmd();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= RegScanEn;
    cfg_data_i       <= '0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.opcode    <= OpTick;
    cmd_ch.position  <= '0;
    cmd_ch.value_bit <= 1'b0;
    mirror_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pattern_ops();
    test_scan_disable();
    test_levels_and_spares();
    test_fast_blink();
    test_random_scan();
    test_steady_stream();
    test_result_hold_off();
    test_sender_pause();

    // Drain, then give the two-stage pipe time to show any stray beat.
    settle_pipeline();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && led_frames_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
